@@ hw/rtl/dvrt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance-vector route table package
// Shared constants, request codes and the table entry type.
// ----------------------------------------------------------------------------
package dvrt_pkg;

  localparam int TABLE_ENTRIES_DEF = 32;
  localparam int ADDR_W            = 5;
  localparam int HOP_W             = 8;
  localparam int MAX_RESULTS       = 31;
  localparam int CNT_W             = 5;

  localparam logic [HOP_W-1:0]  HOPS_UNKNOWN  = 8'hFF;
  localparam logic [ADDR_W-1:0] OWN_ADDR_RST  = 5'd1;
  localparam logic [HOP_W-1:0]  HOP_LIMIT_RST = 8'd15;

  localparam logic CFG_OWN_ADDRESS = 1'b0;
  localparam logic CFG_HOP_LIMIT   = 1'b1;

  typedef enum logic [2:0] {
    REQ_HEADER = 3'd0,
    REQ_ENTRY  = 3'd1,
    REQ_AGE    = 3'd2,
    REQ_LOOKUP = 3'd3,
    REQ_DUMP   = 3'd4
  } req_type_t;

  typedef struct packed {
    logic [ADDR_W-1:0] next_hop;
    logic [HOP_W-1:0]  hop_count;
  } entry_t;

endpackage

@@ hw/rtl/distance_vector_route_table_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Distance-vector route table unit
// Keeps a next hop and hop count per address and serves routing requests.
// ----------------------------------------------------------------------------
// The input stream carries one request per transfer, its kind in in_tuser.
// Every request produces one result on the output stream, except a dump,
// which lists each known entry from address 1 upward (at most 31 results)
// and ends with out_tlast; a dump with nothing known gives one null result.
// Header, entry and lookup requests read their entry from the table RAM in
// the cycle of acceptance and finish in S_EXEC once the output register is
// free; a new request is taken only when the unit is back in idle. An age
// tick walks every entry with a read (S_AGE_RD) and a write (S_AGE_WR) each;
// its null result leaves from S_NULL. A dump reads each entry it visits in
// S_DUMP_RD, judges it in S_DUMP_EV and ends in S_DUMP_END. The table RAM has
// one read and one write port. A finished result sits in the output register
// while the unit works on; when the receiver stalls, the unit waits only at
// the point where it needs to load another result. Reset clears one valid
// bit per entry, so every entry reads as unknown at once with no clearing pass.
// Configuration is written through cfg_we, cfg_addr and cfg_wdata.
// ----------------------------------------------------------------------------
module distance_vector_route_table_unit #(
  parameter int TABLE_ENTRIES = dvrt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // sender_address[7:0], target_address[15:8], advertised_hops[23:16]
  input  logic [23:0] in_tdata,
  // req_type[2:0]
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // entry_address[4:0], next_hop[9:5], hop_count[17:10]
  output logic [23:0] out_tdata,
  // entry_valid[0], entry_changed[1]
  output logic [1:0]  out_tuser,
  output logic        out_tlast
);

  import dvrt_pkg::*;

  localparam int AW = $clog2(TABLE_ENTRIES);
  localparam logic [AW-1:0] LAST_IDX = AW'(TABLE_ENTRIES - 1);
  localparam logic [8:0] N_ENT = 9'(TABLE_ENTRIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_NULL,
    S_AGE_RD,
    S_AGE_WR,
    S_DUMP_RD,
    S_DUMP_EV,
    S_DUMP_END
  } state_t;

  state_t             state_r, state_nxt;
  logic [AW-1:0]      idx_r, idx_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  req_type_t          typ_r, typ_nxt;
  logic [7:0]         snd_r, snd_nxt;
  logic [7:0]         tgt_r, tgt_nxt;
  logic [7:0]         adv_r, adv_nxt;
  logic [ADDR_W-1:0]  own_r, own_nxt;
  logic [HOP_W-1:0]   lim_r, lim_nxt;
  logic [TABLE_ENTRIES-1:0] vld_r, vld_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic               pend_vld_r, pend_vld_nxt;
  logic [ADDR_W-1:0]  pend_addr_r, pend_addr_nxt;
  entry_t             pend_ent_r, pend_ent_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0]  out_addr_r, out_addr_nxt;
  entry_t             out_ent_r, out_ent_nxt;
  logic               out_ev_r, out_ev_nxt;
  logic               out_ec_r, out_ec_nxt;
  logic               out_last_r, out_last_nxt;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [AW-1:0]      ram_raddr;
  entry_t             ram_rdata;
  entry_t             cur;
  logic               out_free;
  logic               in_acc;

  dvrt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign cur.next_hop  = rd_vld_r ? ram_rdata.next_hop : '0;
  assign cur.hop_count = rd_vld_r ? ram_rdata.hop_count : HOPS_UNKNOWN;
  assign out_free      = !out_valid_r || out_tready;
  assign in_tready     = (state_r == S_IDLE);
  assign in_acc        = in_tvalid && in_tready;

  always_comb begin
    logic             emit;
    logic [ADDR_W-1:0] e_addr;
    entry_t           e_ent;
    logic             e_v;
    logic             e_c;
    logic             e_last;
    logic [8:0]       hops;
    logic [8:0]       inc;
    logic             snd_ok;
    logic             tgt_ok;
    logic             known;
    logic             done;
    entry_t           nw;
    req_type_t        in_typ;

    emit   = 1'b0;
    e_addr = '0;
    e_ent  = '0;
    e_v    = 1'b0;
    e_c    = 1'b0;
    e_last = 1'b1;
    hops   = {1'b0, adv_r} + 9'd1;
    inc    = (cur.hop_count != HOPS_UNKNOWN) ? {1'b0, cur.hop_count} + 9'd1
                                              : {1'b0, cur.hop_count};
    snd_ok = {1'b0, snd_r} < N_ENT;
    tgt_ok = {1'b0, tgt_r} < N_ENT;
    known  = cur.hop_count != HOPS_UNKNOWN;
    done   = 1'b0;
    nw     = '0;
    in_typ = req_type_t'(in_tuser);

    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    typ_nxt       = typ_r;
    snd_nxt       = snd_r;
    tgt_nxt       = tgt_r;
    adv_nxt       = adv_r;
    own_nxt       = own_r;
    lim_nxt       = lim_r;
    vld_nxt       = vld_r;
    rd_vld_nxt    = rd_vld_r;
    pend_vld_nxt  = pend_vld_r;
    pend_addr_nxt = pend_addr_r;
    pend_ent_nxt  = pend_ent_r;

    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;

    if (cfg_we) begin
      case (cfg_addr)
        CFG_OWN_ADDRESS: own_nxt = cfg_wdata[ADDR_W-1:0];
        CFG_HOP_LIMIT:   lim_nxt = cfg_wdata;
        default:         ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          typ_nxt = in_typ;
          snd_nxt = in_tdata[7:0];
          tgt_nxt = in_tdata[15:8];
          adv_nxt = in_tdata[23:16];
          case (in_typ)
            REQ_HEADER: begin
              ram_re    = 1'b1;
              ram_raddr = AW'(in_tdata[7:0]);
              state_nxt = S_EXEC;
            end
            REQ_ENTRY, REQ_LOOKUP: begin
              ram_re    = 1'b1;
              ram_raddr = AW'(in_tdata[15:8]);
              state_nxt = S_EXEC;
            end
            REQ_AGE: begin
              idx_nxt   = '0;
              state_nxt = S_AGE_RD;
            end
            REQ_DUMP: begin
              idx_nxt      = AW'(1);
              cnt_nxt      = '0;
              pend_vld_nxt = 1'b0;
              state_nxt    = S_DUMP_RD;
            end
            default: state_nxt = S_NULL;
          endcase
        end
      end

      S_EXEC: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          case (typ_r)
            REQ_HEADER: begin
              if (snd_ok) begin
                nw.next_hop  = ADDR_W'(snd_r);
                nw.hop_count = 8'd1;
                ram_we    = 1'b1;
                ram_waddr = AW'(snd_r);
                ram_wdata = nw;
                e_addr    = ADDR_W'(snd_r);
                e_ent     = nw;
                e_v       = 1'b1;
                e_c       = 1'b1;
              end
            end
            REQ_ENTRY: begin
              if (snd_ok && tgt_ok) begin
                e_addr = ADDR_W'(tgt_r);
                e_ent  = cur;
                e_v    = 1'b1;
                if (!(tgt_r == {3'b000, own_r}) && !(hops > {1'b0, lim_r})
                    && ({1'b0, cur.hop_count} > hops)) begin
                  nw.next_hop  = ADDR_W'(snd_r);
                  nw.hop_count = hops[HOP_W-1:0];
                  ram_we    = 1'b1;
                  ram_waddr = AW'(tgt_r);
                  ram_wdata = nw;
                  e_ent     = nw;
                  e_c       = 1'b1;
                end
              end
            end
            REQ_LOOKUP: begin
              if (tgt_ok) begin
                e_addr = ADDR_W'(tgt_r);
                e_ent  = cur;
                e_v    = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      S_NULL: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end

      S_AGE_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
        state_nxt = S_AGE_WR;
      end

      S_AGE_WR: begin
        if (inc > {1'b0, lim_r}) begin
          nw.next_hop  = '0;
          nw.hop_count = HOPS_UNKNOWN;
        end else begin
          nw.next_hop  = cur.next_hop;
          nw.hop_count = inc[HOP_W-1:0];
        end
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        ram_wdata = nw;
        if (idx_r == LAST_IDX) begin
          state_nxt = S_NULL;
        end else begin
          idx_nxt   = idx_r + AW'(1);
          state_nxt = S_AGE_RD;
        end
      end

      S_DUMP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = idx_r;
        state_nxt = S_DUMP_EV;
      end

      S_DUMP_EV: begin
        if (!(known && pend_vld_r && !out_free)) begin
          if (known) begin
            if (pend_vld_r) begin
              emit   = 1'b1;
              e_addr = pend_addr_r;
              e_ent  = pend_ent_r;
              e_v    = 1'b1;
              e_last = 1'b0;
            end
            pend_vld_nxt  = 1'b1;
            pend_addr_nxt = ADDR_W'(idx_r);
            pend_ent_nxt  = cur;
            cnt_nxt       = cnt_r + CNT_W'(1);
          end
          done = (idx_r == LAST_IDX) || (cnt_nxt == CNT_W'(MAX_RESULTS));
          if (done) begin
            state_nxt = S_DUMP_END;
          end else begin
            idx_nxt   = idx_r + AW'(1);
            state_nxt = S_DUMP_RD;
          end
        end
      end

      S_DUMP_END: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
          if (pend_vld_r) begin
            e_addr = pend_addr_r;
            e_ent  = pend_ent_r;
            e_v    = 1'b1;
          end
          pend_vld_nxt = 1'b0;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (ram_re) begin
      rd_vld_nxt = vld_r[ram_raddr];
    end
    if (ram_we) begin
      vld_nxt[ram_waddr] = 1'b1;
    end

    if (emit) begin
      out_valid_nxt = 1'b1;
      out_addr_nxt  = e_addr;
      out_ent_nxt   = e_ent;
      out_ev_nxt    = e_v;
      out_ec_nxt    = e_c;
      out_last_nxt  = e_last;
    end else begin
      out_valid_nxt = out_valid_r && !out_tready;
      out_addr_nxt  = out_addr_r;
      out_ent_nxt   = out_ent_r;
      out_ev_nxt    = out_ev_r;
      out_ec_nxt    = out_ec_r;
      out_last_nxt  = out_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      own_r       <= OWN_ADDR_RST;
      lim_r       <= HOP_LIMIT_RST;
      vld_r       <= '0;
      pend_vld_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      own_r       <= own_nxt;
      lim_r       <= lim_nxt;
      vld_r       <= vld_nxt;
      pend_vld_r  <= pend_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
    typ_r       <= typ_nxt;
    snd_r       <= snd_nxt;
    tgt_r       <= tgt_nxt;
    adv_r       <= adv_nxt;
    rd_vld_r    <= rd_vld_nxt;
    pend_addr_r <= pend_addr_nxt;
    pend_ent_r  <= pend_ent_nxt;
    out_addr_r  <= out_addr_nxt;
    out_ent_r   <= out_ent_nxt;
    out_ev_r    <= out_ev_nxt;
    out_ec_r    <= out_ec_nxt;
    out_last_r  <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_ent_r.hop_count, out_ent_r.next_hop, out_addr_r};
  assign out_tuser  = {out_ec_r, out_ev_r};
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request accepted while the previous one was still in work");

  a_null_result_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |->
      out_tdata == 24'd0 && out_tlast && !out_tuser[1])
    else $error("null result carries entry data or is not last");

  a_changed_is_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> out_tlast && out_tuser[0])
    else $error("changed entry reported inside a dump listing");
`endif

endmodule

@@ hw/rtl/dvrt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module dvrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ test/dvrt_route_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table result checker
// Watches the configuration port and both streams of the route table unit.
// It keeps its own copy of the next-hop and hop-count tables, predicts the
// results of each accepted request, and compares each returned result with
// the oldest prediction field by field.
// ----------------------------------------------------------------------------
module dvrt_route_checker #(
  parameter int TABLE_ENTRIES = dvrt_pkg::TABLE_ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_wdata,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,
  input  logic [2:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int          fail_count,
  output int          open_count,
  output int          checked_count
);

  import dvrt_pkg::*;

  typedef struct packed {
    logic [ADDR_W-1:0] entry_address;
    logic [ADDR_W-1:0] next_hop;
    logic [HOP_W-1:0]  hop_count;
    logic              entry_valid;
    logic              entry_changed;
    logic              last_result;
  } route_result_t;

  logic [ADDR_W-1:0] next_hops  [TABLE_ENTRIES];
  logic [HOP_W-1:0]  hop_counts [TABLE_ENTRIES];
  logic [ADDR_W-1:0] own_addr;
  logic [HOP_W-1:0]  hop_lim;
  route_result_t     expected_routes [$];
  int                mismatches   = 0;
  int                results_seen = 0;

  function automatic route_result_t entry_view(input int addr, input logic changed);
    route_result_t r;
    r.entry_address = addr[ADDR_W-1:0];
    r.next_hop      = next_hops[addr];
    r.hop_count     = hop_counts[addr];
    r.entry_valid   = 1'b1;
    r.entry_changed = changed;
    r.last_result   = 1'b1;
    return r;
  endfunction

  function automatic route_result_t null_view();
    route_result_t r;
    r = '0;
    r.last_result = 1'b1;
    return r;
  endfunction

  task automatic route_table_apply(input logic [2:0] kind, input logic [7:0] snd,
                                   input logic [7:0] tgt, input logic [7:0] adv);
    logic [8:0]    hops;
    route_result_t held;
    int            found;
    hops  = {1'b0, adv} + 9'd1;
    found = 0;
    held  = '0;
    case (kind)
      REQ_HEADER: begin
        if (snd >= TABLE_ENTRIES) begin
          expected_routes.push_back(null_view());
        end else begin
          next_hops[snd]  = snd[ADDR_W-1:0];
          hop_counts[snd] = 8'd1;
          expected_routes.push_back(entry_view(snd, 1'b1));
        end
      end
      REQ_ENTRY: begin
        if (snd >= TABLE_ENTRIES || tgt >= TABLE_ENTRIES) begin
          expected_routes.push_back(null_view());
        end else if (tgt == {3'b000, own_addr} || hops > {1'b0, hop_lim}) begin
          expected_routes.push_back(entry_view(tgt, 1'b0));
        end else if ({1'b0, hop_counts[tgt]} > hops) begin
          next_hops[tgt]  = snd[ADDR_W-1:0];
          hop_counts[tgt] = hops[HOP_W-1:0];
          expected_routes.push_back(entry_view(tgt, 1'b1));
        end else begin
          expected_routes.push_back(entry_view(tgt, 1'b0));
        end
      end
      REQ_AGE: begin
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
          if (hop_counts[i] != HOPS_UNKNOWN) hop_counts[i] = hop_counts[i] + 8'd1;
          if (hop_counts[i] > hop_lim) begin
            next_hops[i]  = '0;
            hop_counts[i] = HOPS_UNKNOWN;
          end
        end
        expected_routes.push_back(null_view());
      end
      REQ_LOOKUP: begin
        if (tgt >= TABLE_ENTRIES) expected_routes.push_back(null_view());
        else expected_routes.push_back(entry_view(tgt, 1'b0));
      end
      REQ_DUMP: begin
        for (int i = 1; i < TABLE_ENTRIES && found < MAX_RESULTS; i++) begin
          if (hop_counts[i] != HOPS_UNKNOWN) begin
            if (found > 0) expected_routes.push_back(held);
            held = entry_view(i, 1'b0);
            held.last_result = 1'b0;
            found++;
          end
        end
        if (found == 0) begin
          expected_routes.push_back(null_view());
        end else begin
          held.last_result = 1'b1;
          expected_routes.push_back(held);
        end
      end
      default: expected_routes.push_back(null_view());
    endcase
  endtask

  task automatic report_route(input string what, input route_result_t r);
    $display("  %s: addr=%0d next_hop=%0d hops=%0d valid=%b changed=%b last=%b",
             what, r.entry_address, r.next_hop, r.hop_count, r.entry_valid,
             r.entry_changed, r.last_result);
  endtask

  always @(posedge clk) begin
    route_result_t got;
    route_result_t want;
    if (!rst_n) begin
      own_addr = OWN_ADDR_RST;
      hop_lim  = HOP_LIMIT_RST;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        next_hops[i]  = '0;
        hop_counts[i] = HOPS_UNKNOWN;
      end
      expected_routes.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got.entry_address = out_tdata[4:0];
        got.next_hop      = out_tdata[9:5];
        got.hop_count     = out_tdata[17:10];
        got.entry_valid   = out_tuser[0];
        got.entry_changed = out_tuser[1];
        got.last_result   = out_tlast;
        results_seen++;
        if (expected_routes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("[%0t] Result arrived with no request pending.", $time);
            report_route("got", got);
          end
        end else begin
          want = expected_routes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("[%0t] Route result mismatch.", $time);
              report_route("expected", want);
              report_route("got     ", got);
            end
          end
        end
      end
      if (cfg_we) begin
        if (cfg_addr == CFG_OWN_ADDRESS) own_addr = cfg_wdata[ADDR_W-1:0];
        else hop_lim = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        route_table_apply(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
      end
    end
    fail_count    <= mismatches;
    open_count    <= expected_routes.size();
    checked_count <= results_seen;
  end

endmodule

@@ test/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Route table unit testbench
// Drives directed and random routing requests into the route table unit
// under several register settings and idle patterns on both streams, while
// the route checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
  import dvrt_pkg::*;

  localparam int TABLE_ENTRIES    = TABLE_ENTRIES_DEF;
  localparam int SETTLE_CYCLES    = 2 * TABLE_ENTRIES + 16;
  localparam int STALL_LIMIT      = 4000;
  localparam int RANDOM_PER_PHASE = 73;
  localparam int PHASES           = 6;

  localparam logic [2:0] REQ_SPARE_FIRST = 3'd5;
  localparam logic [2:0] REQ_SPARE_LAST  = 3'd7;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = 1'b0;
  logic [7:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;

  int fail_count;
  int open_count;
  int checked_count;
  int send_idle_pct = 8;
  int recv_idle_pct = 67;
  int quiet_cycles  = 0;
  int kind_count [8];

  logic [ADDR_W-1:0] own_now = OWN_ADDR_RST;
  logic [HOP_W-1:0]  lim_now = HOP_LIMIT_RST;

  logic [ADDR_W-1:0] phase_own [PHASES] = '{5'd0, 5'd31, 5'd7, 5'd1, 5'd19, 5'd0};
  logic [HOP_W-1:0]  phase_lim [PHASES] = '{8'd254, 8'd1, 8'd15, 8'd3, 8'd100, 8'd254};

  always #2 clk = ~clk;

  distance_vector_route_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  dvrt_route_checker #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tuser     (out_tuser),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .open_count    (open_count),
    .checked_count (checked_count)
  );

  always @(posedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Timeout: no transfer for %0d cycles, %0d results still pending.",
                 STALL_LIMIT, open_count);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end

  task automatic send_req(input logic [2:0] kind, input logic [7:0] snd,
                          input logic [7:0] tgt, input logic [7:0] adv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= kind;
    in_tdata  <= {adv, tgt, snd};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    kind_count[kind]++;
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_count != 0) @(posedge clk);
  endtask

  task automatic settle();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_settings(input logic [ADDR_W-1:0] own, input logic [HOP_W-1:0] lim);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_OWN_ADDRESS;
    cfg_wdata <= {3'b000, own};
    @(posedge clk);
    cfg_addr  <= CFG_HOP_LIMIT;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
    own_now = own;
    lim_now = lim;
  endtask

  task automatic random_req();
    int         pick;
    logic [2:0] kind;
    logic [7:0] snd;
    logic [7:0] tgt;
    logic [7:0] adv;
    pick = $urandom_range(99);
    snd  = 8'($urandom_range(TABLE_ENTRIES - 1));
    tgt  = 8'($urandom_range(TABLE_ENTRIES - 1));
    adv  = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom_range(lim_now));
    if (pick < 15) begin
      kind = REQ_HEADER;
    end else if (pick < 58) begin
      kind = REQ_ENTRY;
      if ($urandom_range(9) == 0) tgt = {3'b000, own_now};
    end else if (pick < 66) begin
      kind = REQ_AGE;
    end else if (pick < 80) begin
      kind = REQ_LOOKUP;
    end else if (pick < 87) begin
      kind = REQ_DUMP;
    end else begin
      kind = 3'($urandom_range(7));
      snd  = 8'($urandom_range(255));
      tgt  = 8'($urandom_range(255));
      adv  = 8'($urandom_range(255));
    end
    send_req(kind, snd, tgt, adv);
  endtask

  initial begin
    int spare;
    foreach (kind_count[k]) kind_count[k] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_req(REQ_LOOKUP, 8'd0, 8'd0, 8'd0);
    send_req(REQ_DUMP, 8'd0, 8'd0, 8'd0);
    send_req(REQ_HEADER, 8'hFF, 8'd0, 8'd0);
    send_req(REQ_HEADER, 8'd2, 8'd0, 8'd0);
    send_req(REQ_HEADER, 8'd31, 8'd0, 8'd0);
    send_req(REQ_ENTRY, 8'd2, 8'd0, 8'd0);
    send_req(REQ_ENTRY, 8'd2, {3'b000, OWN_ADDR_RST}, 8'd0);
    send_req(REQ_ENTRY, 8'd2, 8'd9, 8'hFF);
    send_req(REQ_ENTRY, 8'd31, 8'd5, HOP_LIMIT_RST - 8'd1);
    send_req(REQ_ENTRY, 8'd31, 8'd6, HOP_LIMIT_RST);
    send_req(REQ_ENTRY, 8'd31, 8'd0, 8'd3);
    send_req(REQ_ENTRY, 8'd31, 8'd5, 8'd4);
    send_req(REQ_ENTRY, 8'd200, 8'd3, 8'd0);
    send_req(REQ_ENTRY, 8'd2, 8'd32, 8'd0);
    send_req(REQ_LOOKUP, 8'd0, 8'hFF, 8'd0);
    send_req(REQ_LOOKUP, 8'hFF, 8'd5, 8'hFF);
    send_req(REQ_DUMP, 8'd0, 8'd0, 8'd0);
    send_req(REQ_ENTRY, 8'd2, 8'd7, HOP_LIMIT_RST - 8'd1);
    send_req(REQ_AGE, 8'd0, 8'd0, 8'd0);
    send_req(REQ_DUMP, 8'd0, 8'd0, 8'd0);
    for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++) begin
      send_req(3'(k), 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
    end
    settle();

    for (int p = 0; p < PHASES; p++) begin
      if (p < 2) begin
        send_idle_pct = 8;
        recv_idle_pct = 67;
      end else if (p < 4) begin
        send_idle_pct = 67;
        recv_idle_pct = 8;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_settings(phase_own[p], phase_lim[p]);
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        if (n == RANDOM_PER_PHASE / 2) drain_results();
        random_req();
      end
      settle();
    end

    spare = 0;
    for (int k = REQ_SPARE_FIRST; k <= REQ_SPARE_LAST; k++) spare += kind_count[k];
    $display("Covered %0d headers, %0d adverts, %0d age ticks, %0d lookups, %0d dumps",
             kind_count[REQ_HEADER], kind_count[REQ_ENTRY], kind_count[REQ_AGE],
             kind_count[REQ_LOOKUP], kind_count[REQ_DUMP]);
    $display("and %0d unused codes; %0d results checked over %0d register settings.",
             spare, checked_count, PHASES + 1);
    if (fail_count == 0 && open_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
